// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define SIP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sip assertion failed");

// implication checked at every rising clock edge outside reset
`define SIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sip assertion failed");

`endif

// ===== design/sip_pkg.sv =====
// types and constants for the segment intersection pipeline
`default_nettype none
package sip_pkg;
    localparam int COORD_W = 16;
    localparam int FRAC_W  = 16;
    localparam int QUO_W   = FRAC_W + 1;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DOT_W   = PROD_W + 1;
    localparam int MAG_W   = DOT_W - 1;
    localparam int DEN_W   = MAG_W + 1;
    localparam int LANES   = 2;
    localparam int LANE_P  = 0;
    localparam int LANE_Q  = 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [DOT_W-1:0]   t_dot;
    typedef logic [MAG_W-1:0]          t_mag;
    typedef logic [QUO_W-1:0]          t_alpha;

    typedef struct packed {
        t_coord p_start_x;
        t_coord p_start_y;
        t_coord p_end_x;
        t_coord p_end_y;
        t_coord q_start_x;
        t_coord q_start_y;
        t_coord q_end_x;
        t_coord q_end_y;
    } t_in_item;

    typedef struct packed {
        logic   hit;
        logic   degenerate;
        t_alpha alpha_p;
        t_alpha alpha_q;
    } t_out_item;

    // side distances and classification handed to the divider
    typedef struct packed {
        logic hit;
        logic degen;
        t_mag mag_p0;
        t_mag mag_p1;
        t_mag mag_q0;
        t_mag mag_q1;
    } t_side;
endpackage
`default_nettype wire

// ===== design/segment_intersection_params_top.sv =====
// top level of the 2d segment intersection parameter pipeline
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------
//  input    | in        | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  output   | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// one transaction per cycle sustained while the output is not stalled
// the pipeline is 4 stages of distance math, 1 divisor stage, 17 quotient bit stages
// synchronous active low reset clears only the valid bits
// a stalled result freezes the whole pipeline; no transaction is lost or repeated
`default_nettype none
module segment_intersection_params_top import sip_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);
    logic  en;
    logic  side_valid;
    t_side side;

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    sip_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_valid (side_valid),
        .o_side  (side)
    );

    sip_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (side_valid),
        .i_side  (side),
        .o_valid (o_out_valid),
        .o_item  (o_out_data)
    );
endmodule
`default_nettype wire

// ===== design/sip_dist.sv =====
// differences, products, side distances and straddle tests over four stages
`default_nettype none
module sip_dist import sip_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_valid,
    output t_side         o_side
);
    t_diff r_nqx, r_nqy, r_npx, r_npy;
    t_diff r_d0x, r_d0y, r_d1x, r_d1y, r_e0x, r_e0y, r_e1x, r_e1y;
    t_prod r_m [8];
    t_dot  r_wp0, r_wp1, r_wq0, r_wq1;
    t_side r_side;
    logic  r_v1, r_v2, r_v3, r_v4;

    logic  z_p0, z_p1, z_q0, z_q1, s_p, s_q, hit;

    function automatic t_diff f_sub(input t_coord a, input t_coord b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic t_mag f_abs(input t_dot v);
        t_dot n;
        n = -v;
        return v[DOT_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 1: normals and point differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nqx <= f_sub(i_item.q_start_y, i_item.q_end_y);
            r_nqy <= f_sub(i_item.q_end_x, i_item.q_start_x);
            r_npx <= f_sub(i_item.p_start_y, i_item.p_end_y);
            r_npy <= f_sub(i_item.p_end_x, i_item.p_start_x);
            r_d0x <= f_sub(i_item.p_start_x, i_item.q_start_x);
            r_d0y <= f_sub(i_item.p_start_y, i_item.q_start_y);
            r_d1x <= f_sub(i_item.p_end_x, i_item.q_start_x);
            r_d1y <= f_sub(i_item.p_end_y, i_item.q_start_y);
            r_e0x <= f_sub(i_item.q_start_x, i_item.p_start_x);
            r_e0y <= f_sub(i_item.q_start_y, i_item.p_start_y);
            r_e1x <= f_sub(i_item.q_end_x, i_item.p_start_x);
            r_e1y <= f_sub(i_item.q_end_y, i_item.p_start_y);
        end
    end

    // stage 2: products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= PROD_W'(r_d0x) * PROD_W'(r_nqx);
            r_m[1] <= PROD_W'(r_d0y) * PROD_W'(r_nqy);
            r_m[2] <= PROD_W'(r_d1x) * PROD_W'(r_nqx);
            r_m[3] <= PROD_W'(r_d1y) * PROD_W'(r_nqy);
            r_m[4] <= PROD_W'(r_e0x) * PROD_W'(r_npx);
            r_m[5] <= PROD_W'(r_e0y) * PROD_W'(r_npy);
            r_m[6] <= PROD_W'(r_e1x) * PROD_W'(r_npx);
            r_m[7] <= PROD_W'(r_e1y) * PROD_W'(r_npy);
        end
    end

    // stage 3: dot products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wp0 <= DOT_W'(r_m[0]) + DOT_W'(r_m[1]);
            r_wp1 <= DOT_W'(r_m[2]) + DOT_W'(r_m[3]);
            r_wq0 <= DOT_W'(r_m[4]) + DOT_W'(r_m[5]);
            r_wq1 <= DOT_W'(r_m[6]) + DOT_W'(r_m[7]);
        end
    end

    // stage 4: straddle tests and magnitudes
    always_comb begin
        z_p0 = (r_wp0 == '0);
        z_p1 = (r_wp1 == '0);
        z_q0 = (r_wq0 == '0);
        z_q1 = (r_wq1 == '0);
        s_p  = z_p0 || z_p1 || (r_wp0[DOT_W-1] != r_wp1[DOT_W-1]);
        s_q  = z_q0 || z_q1 || (r_wq0[DOT_W-1] != r_wq1[DOT_W-1]);
        hit  = s_p && s_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side.hit    <= hit;
            r_side.degen  <= hit && ((z_p0 && z_p1) || (z_q0 && z_q1));
            r_side.mag_p0 <= f_abs(r_wp0);
            r_side.mag_p1 <= f_abs(r_wp1);
            r_side.mag_q0 <= f_abs(r_wq0);
            r_side.mag_q1 <= f_abs(r_wq1);
        end
    end

    assign o_valid = r_v4;
    assign o_side  = r_side;
endmodule
`default_nettype wire

// ===== design/sip_div.sv =====
// pipelined restoring divider, one quotient bit per stage, both lanes
`default_nettype none
module sip_div import sip_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_side i_side,
    output logic       o_valid,
    output t_out_item  o_item
);
    logic [MAG_W-1:0] r_num [LANES];
    logic [DEN_W-1:0] r_dvs [LANES];
    logic             r_v0, r_h0, r_g0;

    logic [DEN_W-1:0] r_rem [LANES][QUO_W];
    logic [DEN_W-1:0] r_den [LANES][QUO_W];
    t_alpha           r_quo [LANES][QUO_W];
    logic             r_vld [QUO_W];
    logic             r_hit [QUO_W];
    logic             r_deg [QUO_W];

    logic             keep;
    logic [MAG_W-1:0] num_in [LANES];
    logic [MAG_W-1:0] oth_in [LANES];

    always_comb begin
        keep           = i_side.hit && !i_side.degen;
        num_in[LANE_P] = i_side.mag_p0;
        oth_in[LANE_P] = i_side.mag_p1;
        num_in[LANE_Q] = i_side.mag_q0;
        oth_in[LANE_Q] = i_side.mag_q1;
    end

    // divisor setup; a miss or degenerate case divides zero by one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h0 <= i_side.hit;
            r_g0 <= i_side.degen;
            for (int l = 0; l < LANES; l++) begin
                r_num[l] <= keep ? num_in[l] : '0;
                r_dvs[l] <= keep ? (DEN_W'(num_in[l]) + DEN_W'(oth_in[l]))
                                 : DEN_W'(1);
            end
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic prev_v, prev_h, prev_g;
        assign prev_v = (k == 0) ? r_v0 : r_vld[(k == 0) ? 0 : k-1];
        assign prev_h = (k == 0) ? r_h0 : r_hit[(k == 0) ? 0 : k-1];
        assign prev_g = (k == 0) ? r_g0 : r_deg[(k == 0) ? 0 : k-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= prev_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_hit[k] <= prev_h;
                r_deg[k] <= prev_g;
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W-1:0] rem_in, den_in;
            t_alpha           quo_in;
            logic [DEN_W:0]   trial, diff;
            logic             ge;

            assign rem_in = (k == 0) ? DEN_W'(r_num[l]) : r_rem[l][(k == 0) ? 0 : k-1];
            assign den_in = (k == 0) ? r_dvs[l] : r_den[l][(k == 0) ? 0 : k-1];
            assign quo_in = (k == 0) ? '0 : r_quo[l][(k == 0) ? 0 : k-1];
            assign trial  = (k == 0) ? {1'b0, rem_in} : {rem_in, 1'b0};
            assign diff   = trial - {1'b0, den_in};
            assign ge     = (trial >= {1'b0, den_in});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[l][k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    r_den[l][k] <= den_in;
                    r_quo[l][k] <= {quo_in[QUO_W-2:0], ge};
                end
            end
        end
    end

    assign o_valid            = r_vld[QUO_W-1];
    assign o_item.hit         = r_hit[QUO_W-1];
    assign o_item.degenerate  = r_deg[QUO_W-1];
    assign o_item.alpha_p     = r_quo[LANE_P][QUO_W-1];
    assign o_item.alpha_q     = r_quo[LANE_Q][QUO_W-1];
endmodule
`default_nettype wire

// ===== design/sip_checker.sv =====
// port level checks for the segment intersection top level
`default_nettype none
`include "assert_macros.svh"
module sip_checker import sip_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);
    logic alphas_zero, p_ok, q_ok;

    assign alphas_zero = (o_out_data.alpha_p == '0) && (o_out_data.alpha_q == '0);
    assign p_ok = !o_out_data.alpha_p[FRAC_W] || (o_out_data.alpha_p[FRAC_W-1:0] == '0);
    assign q_ok = !o_out_data.alpha_q[FRAC_W] || (o_out_data.alpha_q[FRAC_W-1:0] == '0);

    `SIP_ASSERT_IMPL(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall, ##1 (i_in_valid && $stable(i_in_data)))
    `SIP_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, ##1 (o_out_valid && $stable(o_out_data)))
    `SIP_ASSERT_IMPL(a_deg, i_clk, i_rst_n, o_out_valid && o_out_data.degenerate, o_out_data.hit && alphas_zero)
    `SIP_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.hit, alphas_zero)
    `SIP_ASSERT(a_range, i_clk, i_rst_n, !o_out_valid || (p_ok && q_ok))
endmodule

bind segment_intersection_params_top sip_checker u_sip_checker (.*);
`default_nettype wire

// ===== tb/segment_intersection_params_top_tb.sv =====
// testbench for the segment intersection pipeline: scoreboard checks against a predictor
`timescale 1ns / 100ps
`default_nettype none
module segment_intersection_params_top_tb;
    import sip_pkg::*;

    class intersect_board;
        t_out_item expected_q[$];
        int errors;

        function automatic longint dot2(longint ax, longint ay, longint bx, longint by);
            return ax * bx + ay * by;
        endfunction

        function automatic t_alpha frac(longint a, longint b);
            longint ma, mb;
            logic [63:0] num, den;
            ma = a < 0 ? -a : a;
            mb = b < 0 ? -b : b;
            den = ma + mb;
            if (den == 0) return '0;
            num = ma << FRAC_W;
            return t_alpha'(num / den);
        endfunction

        function automatic t_out_item predict(t_in_item d);
            t_out_item r;
            longint psx, psy, pex, pey, qsx, qsy, qex, qey;
            longint wp0, wp1, wq0, wq1;
            psx = d.p_start_x; psy = d.p_start_y; pex = d.p_end_x; pey = d.p_end_y;
            qsx = d.q_start_x; qsy = d.q_start_y; qex = d.q_end_x; qey = d.q_end_y;
            r = '0;
            wp0 = dot2(psx - qsx, psy - qsy, qsy - qey, qex - qsx);
            wp1 = dot2(pex - qsx, pey - qsy, qsy - qey, qex - qsx);
            if (!(wp0 == 0 || wp1 == 0 || ((wp0 < 0) != (wp1 < 0)))) return r;
            wq0 = dot2(qsx - psx, qsy - psy, psy - pey, pex - psx);
            wq1 = dot2(qex - psx, qey - psy, psy - pey, pex - psx);
            if (!(wq0 == 0 || wq1 == 0 || ((wq0 < 0) != (wq1 < 0)))) return r;
            r.hit = 1'b1;
            if ((wp0 == 0 && wp1 == 0) || (wq0 == 0 && wq1 == 0)) begin
                r.degenerate = 1'b1;
                return r;
            end
            r.alpha_p = frac(wp0, wp1);
            r.alpha_q = frac(wq0, wq1);
            return r;
        endfunction

        function void note_input(t_in_item d);
            expected_q.push_back(predict(d));
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.hit !== e.hit) begin
                $display("%0t hit expected %0d actual %0d", $time, e.hit, got.hit);
                errors++;
            end
            if (got.degenerate !== e.degenerate) begin
                $display("%0t degenerate expected %0d actual %0d", $time, e.degenerate,
                         got.degenerate);
                errors++;
            end
            if (got.alpha_p !== e.alpha_p) begin
                $display("%0t alpha_p expected %0h actual %0h", $time, e.alpha_p, got.alpha_p);
                errors++;
            end
            if (got.alpha_q !== e.alpha_q) begin
                $display("%0t alpha_q expected %0h actual %0h", $time, e.alpha_q, got.alpha_q);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_data;

    intersect_board board = new();
    bit no_idle = 1'b0;
    bit stim_done = 1'b0;

    segment_intersection_params_top dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) board.note_input(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_data);
    end

    always @(negedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(99) < 26);
    end

    task automatic send_pair(t_in_item d);
        while (!no_idle && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_coord pick_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(32) - 16);
            default: begin
                case ($urandom_range(3))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return '0;
                    default: return t_coord'($urandom_range(2) - 1);
                endcase
            end
        endcase
    endfunction

    function automatic t_in_item rand_pair();
        t_in_item d;
        int mode;
        mode = $urandom_range(2);
        d.p_start_x = pick_coord(mode); d.p_start_y = pick_coord(mode);
        d.p_end_x = pick_coord(mode);   d.p_end_y = pick_coord(mode);
        d.q_start_x = pick_coord(mode); d.q_start_y = pick_coord(mode);
        d.q_end_x = pick_coord(mode);   d.q_end_y = pick_coord(mode);
        case ($urandom_range(5))
            0: begin
                d.q_start_x = d.p_start_x; d.q_start_y = d.p_start_y;
            end
            1: begin
                d.q_end_x = d.p_end_x; d.q_end_y = d.p_end_y;
            end
            2: begin
                d.q_start_x = d.p_end_x; d.q_start_y = d.p_start_y;
                d.q_end_x = d.p_start_x; d.q_end_y = d.p_end_y;
            end
            default: ;
        endcase
        return d;
    endfunction

    function automatic t_in_item seg(int a, int b, int c, int e, int f, int g, int h, int k);
        t_in_item d;
        d.p_start_x = t_coord'(a); d.p_start_y = t_coord'(b);
        d.p_end_x = t_coord'(c);   d.p_end_y = t_coord'(e);
        d.q_start_x = t_coord'(f); d.q_start_y = t_coord'(g);
        d.q_end_x = t_coord'(h);   d.q_end_y = t_coord'(k);
        return d;
    endfunction

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_pair(seg(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(seg(0, 0, 10, 0, 5, 0, 5, 10));
        send_pair(seg(0, 0, 10, 0, 0, 0, 0, 10));
        send_pair(seg(0, 0, 10, 0, 0, 5, 10, 5));
        send_pair(seg(0, 0, 10, 0, 2, 0, 20, 0));
        send_pair(seg(0, 0, 10, 0, 20, 0, 30, 0));
        send_pair(seg(3, 3, 3, 3, 0, 0, 6, 6));
        send_pair(seg(3, 3, 3, 3, 3, 3, 3, 3));
        send_pair(seg(0, 0, 10, 0, 10, 0, 10, 5));
        send_pair(seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(seg(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        send_pair(seg(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        send_pair(seg(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
        send_pair(seg(0, 0, 1, 0, 1, -1, 0, 32767));
        send_pair(seg(0, 0, 3, 0, 1, -1, 1, 2));
        send_pair(seg(-1, -1, -1, -1, -1, -1, -1, -1));
        send_pair(seg(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
        for (int i = 0; i < 550; i++) begin
            no_idle = (i >= 150 && i < 250);
            if (i == 300) begin
                i_in_valid <= 1'b0;
                while (board.expected_q.size() != 0) @(negedge i_clk);
            end
            send_pair(rand_pair());
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;
        while (board.expected_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
